>>> src/mic1_pkg.sv
// ----------------------------------------------------------------------------
// mic1_pkg
// Shared constants for the microprogrammed stack datapath: ops, sizes, fields.
// ----------------------------------------------------------------------------
`default_nettype none

package mic1_pkg;

    localparam int MEMORY_WORDS  = 16384;
    localparam int CONTROL_WORDS = 512;
    localparam int MEM_AW        = $clog2(MEMORY_WORDS);
    localparam int CS_AW         = $clog2(CONTROL_WORDS);

    localparam logic [2:0] OP_LOAD_CW   = 3'd0;
    localparam logic [2:0] OP_WRITE_MEM = 3'd1;
    localparam logic [2:0] OP_READ_MEM  = 3'd2;
    localparam logic [2:0] OP_RESTART   = 3'd3;
    localparam logic [2:0] OP_STEP      = 3'd4;

    localparam logic [1:0] CFG_ENTRY = 2'd0;
    localparam logic [1:0] CFG_H     = 2'd1;
    localparam logic [1:0] CFG_CPP   = 2'd2;
    localparam logic [1:0] CFG_SP    = 2'd3;

    localparam logic [3:0] B_HALT = 4'd15;

endpackage

`default_nettype wire

>>> src/microprogrammed_stack_cpu_datapath_top.sv
// ----------------------------------------------------------------------------
// microprogrammed_stack_cpu_datapath_top
// Mic-1 style datapath: control store, data memory, registers, ALU, shifter.
// ----------------------------------------------------------------------------
// usage:
//   command channel: an item is taken when start is high and busy is low;
//   op selects load control word, write memory, read memory, restart or step.
//   every item gives one result, shown for one cycle with done high.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data sets the
//   restart values; cfg_ready is always high.
// sequence:
//   every item goes through these steps from start to done: the control
//   store is read at mpc, then data memory (pending read, fetch or op read),
//   then the result is written back and presented; busy stays high
//   meanwhile, so a new item is taken only once the last one is through.
// reset:
//   registers and flags clear at once; data memory is then cleared one word
//   a cycle, all 16384 words, with busy high. the control store is not cleared.
//   the receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module microprogrammed_stack_cpu_datapath_top
    import mic1_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         op,
    input  wire logic [13:0]        address,
    input  wire logic [35:0]        data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    done,
    output logic signed [31:0]      read_data,
    output logic signed [31:0]      top_of_stack,
    output logic [8:0]              micro_pc,
    output logic signed [31:0]      program_counter,
    output logic signed [31:0]      stack_pointer,
    output logic                    halted
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CS    = 2'd1;
    localparam logic [1:0] S_MEM   = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [35:0] cs_mem [CONTROL_WORDS];
    logic [31:0] dm_mem [MEMORY_WORDS];

    logic [1:0]  state_reg;
    logic [MEM_AW:0] clr_reg;
    logic [2:0]  op_reg;
    logic [13:0] addr_reg;
    logic [35:0] data_reg;
    logic [8:0]  entry_reg;
    logic [15:0] ih_reg;
    logic [13:0] icpp_reg, isp_reg;
    logic [31:0] mar_reg, mdr_reg, pc_reg, sp_reg, lv_reg, cpp_reg, tos_reg, opc_reg, h_reg;
    logic [7:0]  mbr_reg;
    logic [8:0]  mpc_reg;
    logic        rdp_reg, fp_reg;
    logic [35:0] cw_q;
    logic [31:0] dm_q;
    logic        dm_ok_reg;
    logic [1:0]  lane_reg;

    // memory access address selection
    logic [31:0] dm_a;
    logic        dm_ok;
    always_comb
    begin
        dm_a = {18'd0, addr_reg};
        if (op_reg == OP_STEP)
        begin
            if (fp_reg)
                dm_a = {2'b00, pc_reg[31:2]};
            else
                dm_a = mar_reg;
        end
        dm_ok = (dm_a < 32'(MEMORY_WORDS));
    end

    logic [31:0] mar_q;
    logic        mar_ok_reg;

    // datapath
    logic [35:0] w;
    logic [31:0] b_bus, alu, res;
    logic [8:0]  nxt;
    logic [7:0]  mbr_new;
    logic [31:0] mdr_new;
    logic [31:0] mar_nx, mdr_nx;
    always_comb
    begin
        w = cw_q;
        unique case (w[3:0])
            4'd0: b_bus = mdr_reg;
            4'd1: b_bus = pc_reg;
            4'd2: b_bus = {{24{mbr_reg[7]}}, mbr_reg};
            4'd3: b_bus = {24'd0, mbr_reg};
            4'd4: b_bus = sp_reg;
            4'd5: b_bus = lv_reg;
            4'd6: b_bus = cpp_reg;
            4'd7: b_bus = tos_reg;
            4'd8: b_bus = opc_reg;
            default: b_bus = 32'd0;
        endcase
        unique case (w[21:16])
            6'h18: alu = h_reg;
            6'h14: alu = b_bus;
            6'h1A: alu = ~h_reg;
            6'h2C: alu = ~b_bus;
            6'h3C: alu = h_reg + b_bus;
            6'h3D: alu = h_reg + b_bus + 32'd1;
            6'h39: alu = h_reg + 32'd1;
            6'h35: alu = b_bus + 32'd1;
            6'h3F: alu = b_bus - h_reg;
            6'h36: alu = b_bus - 32'd1;
            6'h3B: alu = 32'd0 - h_reg;
            6'h0C: alu = h_reg & b_bus;
            6'h1C: alu = h_reg | b_bus;
            6'h31: alu = 32'd1;
            6'h32: alu = 32'hFFFF_FFFF;
            default: alu = 32'd0;
        endcase
        res = alu;
        if (w[22])
            res = {res[31], res[31:1]};
        if (w[23])
            res = {res[23:0], 8'd0};
        mdr_new = rdp_reg ? (mar_ok_reg ? mar_q : 32'd0) : mdr_reg;
        mbr_new = mbr_reg;
        if (fp_reg)
            mbr_new = dm_ok_reg ? dm_q[8*lane_reg +: 8] : 8'd0;
        mar_nx = w[7] ? res : mar_reg;
        mdr_nx = w[8] ? res : mdr_new;
        nxt = w[35:27];
        if ((w[24] && res == 32'd0) || (w[25] && res[31]))
            nxt[8] = 1'b1;
        if (w[26])
            nxt = nxt | {1'b0, mbr_new};
    end

    // second memory read, at mar, used for every pending mdr load
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CS)
        begin
            mar_ok_reg <= (mar_reg < 32'(MEMORY_WORDS));
            mar_q <= dm_mem[mar_reg[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start && op == OP_LOAD_CW && address < 14'(CONTROL_WORDS))
            cs_mem[address[CS_AW-1:0]] <= data;
        if (state_reg == S_IDLE)
            cw_q <= cs_mem[mpc_reg];
        if (state_reg == S_CS)
        begin
            dm_q <= dm_mem[dm_a[MEM_AW-1:0]];
            dm_ok_reg <= dm_ok;
            lane_reg <= pc_reg[1:0];
        end
        if (state_reg == S_CLEAR)
            dm_mem[clr_reg[MEM_AW-1:0]] <= 32'd0;
        else if (state_reg == S_MEM && op_reg == OP_WRITE_MEM
                 && 32'(addr_reg) < 32'(MEMORY_WORDS))
            dm_mem[addr_reg[MEM_AW-1:0]] <= data_reg[31:0];
        else if (state_reg == S_MEM && op_reg == OP_STEP && w[6]
                 && mar_nx < 32'(MEMORY_WORDS))
            dm_mem[mar_nx[MEM_AW-1:0]] <= mdr_nx;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg <= op;
            addr_reg <= address;
            data_reg <= data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            entry_reg <= '0; ih_reg <= '0; icpp_reg <= '0; isp_reg <= '0;
            mar_reg <= '0; mdr_reg <= '0; pc_reg <= '0; sp_reg <= '0; lv_reg <= '0;
            cpp_reg <= '0; tos_reg <= '0; opc_reg <= '0; h_reg <= '0;
            mbr_reg <= '0; mpc_reg <= '0; rdp_reg <= 1'b0; fp_reg <= 1'b0;
            done <= 1'b0; read_data <= '0;
        end
        else
        begin
            done <= (state_reg == S_MEM);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ENTRY: entry_reg <= cfg_data[8:0];
                    CFG_H:     ih_reg <= cfg_data;
                    CFG_CPP:   icpp_reg <= cfg_data[13:0];
                    CFG_SP:    isp_reg <= cfg_data[13:0];
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (MEM_AW+1)'(MEMORY_WORDS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (start)
                        state_reg <= S_CS;
                S_CS:
                    state_reg <= S_MEM;
                S_MEM:
                begin
                    state_reg <= S_IDLE;
                    read_data <= (op_reg == OP_READ_MEM && dm_ok_reg) ? dm_q : 32'd0;
                    unique case (op_reg)
                        OP_RESTART:
                        begin
                            mar_reg <= '0; mdr_reg <= '0; pc_reg <= '0; lv_reg <= '0;
                            tos_reg <= '0; opc_reg <= '0;
                            h_reg <= {16'd0, ih_reg};
                            cpp_reg <= {18'd0, icpp_reg};
                            sp_reg <= {18'd0, isp_reg};
                            mbr_reg <= '0; mpc_reg <= entry_reg;
                            rdp_reg <= 1'b0; fp_reg <= 1'b0;
                        end
                        OP_STEP:
                        begin
                            mbr_reg <= mbr_new;
                            mar_reg <= mar_nx;
                            mdr_reg <= mdr_nx;
                            pc_reg <= w[9] ? res : pc_reg;
                            sp_reg <= w[10] ? res : sp_reg;
                            lv_reg <= w[11] ? res : lv_reg;
                            cpp_reg <= w[12] ? res : cpp_reg;
                            tos_reg <= w[13] ? res : tos_reg;
                            opc_reg <= w[14] ? res : opc_reg;
                            h_reg <= w[15] ? res : h_reg;
                            rdp_reg <= w[5];
                            fp_reg <= w[4];
                            mpc_reg <= nxt;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end
    end

    // halted is the b field of the word at the new mpc: read it as mpc updates
    logic [8:0]  mpc_nx;
    logic [35:0] hw_q;
    always_comb
    begin
        mpc_nx = mpc_reg;
        if (state_reg == S_MEM)
        begin
            if (op_reg == OP_RESTART)
                mpc_nx = entry_reg;
            else if (op_reg == OP_STEP)
                mpc_nx = nxt;
        end
    end

    always_ff @(posedge clk)
    begin
        hw_q <= cs_mem[mpc_nx];
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign top_of_stack = tos_reg;
    assign program_counter = pc_reg;
    assign stack_pointer = sp_reg;
    assign micro_pc = mpc_reg;
    assign halted = (hw_q[3:0] == B_HALT);

    assert property (@(posedge clk) disable iff (!rst_n) done |-> state_reg == S_IDLE)
        else $error("done outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> state_reg == S_CS)
        else $error("item not taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CS |=> state_reg == S_MEM)
        else $error("sequence broken");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MEM |=> done)
        else $error("no result");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("busy with result");

endmodule

`default_nettype wire

>>> sim/microprogrammed_stack_cpu_datapath_top_test.sv
// ----------------------------------------------------------------------------
// microprogrammed_stack_cpu_datapath_top_test
// Self-checking regression for the Mic-1 style datapath. The control store is
// filled first, then a table of directed items runs, then random phases, each
// with new restart values. Every item is checked field by field against a
// local model of the datapath, with random gaps between items after the fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module microprogrammed_stack_cpu_datapath_top_test;
    import mic1_pkg::*;

    localparam int LIMIT_CYCLES = 600000;

    localparam logic [3:0] B_MDR = 4'd0;
    localparam logic [3:0] B_PC  = 4'd1;
    localparam logic [3:0] B_MBR = 4'd2;
    localparam logic [3:0] B_MBRU = 4'd3;
    localparam logic [3:0] B_SP  = 4'd4;
    localparam logic [3:0] B_LV  = 4'd5;
    localparam logic [3:0] B_CPP = 4'd6;
    localparam logic [3:0] B_TOS = 4'd7;
    localparam logic [3:0] B_OPC = 4'd8;

    localparam logic [5:0] ALU_A     = 6'h18;
    localparam logic [5:0] ALU_B     = 6'h14;
    localparam logic [5:0] ALU_NA    = 6'h1A;
    localparam logic [5:0] ALU_NB    = 6'h2C;
    localparam logic [5:0] ALU_ADD   = 6'h3C;
    localparam logic [5:0] ALU_ADD1  = 6'h3D;
    localparam logic [5:0] ALU_INCA  = 6'h39;
    localparam logic [5:0] ALU_INCB  = 6'h35;
    localparam logic [5:0] ALU_SUB   = 6'h3F;
    localparam logic [5:0] ALU_DECB  = 6'h36;
    localparam logic [5:0] ALU_NEGA  = 6'h3B;
    localparam logic [5:0] ALU_AND   = 6'h0C;
    localparam logic [5:0] ALU_OR    = 6'h1C;
    localparam logic [5:0] ALU_ZERO  = 6'h10;
    localparam logic [5:0] ALU_ONE   = 6'h31;
    localparam logic [5:0] ALU_MONE  = 6'h32;

    localparam int R_MAR = 0, R_MDR = 1, R_PC = 2, R_SP = 3, R_LV = 4;
    localparam int R_CPP = 5, R_TOS = 6, R_OPC = 7, R_H = 8;

    typedef struct packed {
        logic [31:0] rd;
        logic [31:0] tos;
        logic [8:0]  mpc;
        logic [31:0] pc;
        logic [31:0] sp;
        logic        halt;
    } outcome_t;

    typedef struct {
        logic [2:0]  op;
        logic [13:0] addr;
        logic [35:0] data;
        bit          known;
        logic [31:0] rd;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] op = '0;
    logic [13:0] address = '0;
    logic [35:0] data = '0;
    logic cfg_valid = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic busy, cfg_ready, done, halted;
    logic signed [31:0] read_data, top_of_stack, program_counter, stack_pointer;
    logic [8:0] micro_pc;

    // datapath model state
    logic [35:0] cs_mem [CONTROL_WORDS];
    logic [31:0] dmem [MEMORY_WORDS];
    logic [31:0] regs [9];
    logic [7:0]  mbr;
    logic [8:0]  mpc;
    bit rd_pend, fetch_pend;
    logic [8:0]  entry_cfg;
    logic [15:0] h_cfg;
    logic [13:0] cpp_cfg, sp_cfg;

    outcome_t pending_results[$];
    int mismatches = 0;
    int cycles = 0;
    int items = 0, steps = 0, halts = 0, results = 0;
    bit no_gaps = 0;

    always #10 clk = ~clk;

    microprogrammed_stack_cpu_datapath_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .address(address), .data(data), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .read_data(read_data), .top_of_stack(top_of_stack),
        .micro_pc(micro_pc), .program_counter(program_counter),
        .stack_pointer(stack_pointer), .halted(halted)
    );

    function automatic logic [31:0] b_bus(logic [3:0] code);
        case (code)
            B_MDR:  return regs[R_MDR];
            B_PC:   return regs[R_PC];
            B_MBR:  return {{24{mbr[7]}}, mbr};
            B_MBRU: return {24'd0, mbr};
            B_SP:   return regs[R_SP];
            B_LV:   return regs[R_LV];
            B_CPP:  return regs[R_CPP];
            B_TOS:  return regs[R_TOS];
            B_OPC:  return regs[R_OPC];
            default: return '0;
        endcase
    endfunction

    function automatic logic [31:0] alu(logic [5:0] f, logic [31:0] a, logic [31:0] b);
        case (f)
            ALU_A:    return a;
            ALU_B:    return b;
            ALU_NA:   return ~a;
            ALU_NB:   return ~b;
            ALU_ADD:  return a + b;
            ALU_ADD1: return a + b + 1;
            ALU_INCA: return a + 1;
            ALU_INCB: return b + 1;
            ALU_SUB:  return b - a;
            ALU_DECB: return b - 1;
            ALU_NEGA: return 0 - a;
            ALU_AND:  return a & b;
            ALU_OR:   return a | b;
            ALU_ZERO: return '0;
            ALU_ONE:  return 32'd1;
            ALU_MONE: return '1;
            default:  return '0;
        endcase
    endfunction

    function automatic void microcycle();
        logic [35:0] w;
        logic [31:0] res;
        logic [8:0] nxt;
        w = cs_mem[mpc];
        res = alu(w[21:16], regs[R_H], b_bus(w[3:0]));
        if (w[22])
            res = {res[31], res[31:1]};
        if (w[23])
            res = res << 8;
        if (rd_pend)
        begin
            regs[R_MDR] = (regs[R_MAR] < MEMORY_WORDS) ? dmem[regs[R_MAR]] : '0;
            rd_pend = 0;
        end
        if (fetch_pend)
        begin
            if (regs[R_PC] < MEMORY_WORDS * 4)
                mbr = dmem[regs[R_PC] >> 2] >> (regs[R_PC][1:0] * 8);
            else
                mbr = '0;
            fetch_pend = 0;
        end
        for (int i = 0; i < 9; i++)
            if (w[7 + i])
                regs[i] = res;
        if (w[6] && regs[R_MAR] < MEMORY_WORDS)
            dmem[regs[R_MAR]] = regs[R_MDR];
        if (w[5])
            rd_pend = 1;
        if (w[4])
            fetch_pend = 1;
        nxt = w[35:27];
        if ((w[24] && res == 0) || (w[25] && res[31]))
            nxt[8] = 1'b1;
        if (w[26])
            nxt = nxt | {1'b0, mbr};
        mpc = nxt;
    endfunction

    function automatic outcome_t predict_item(logic [2:0] o, logic [13:0] a, logic [35:0] d);
        outcome_t r;
        r.rd = '0;
        case (o)
            OP_LOAD_CW:
                if (a < CONTROL_WORDS)
                    cs_mem[a] = d;
            OP_WRITE_MEM: dmem[a] = d[31:0];
            OP_READ_MEM: r.rd = dmem[a];
            OP_RESTART:
            begin
                for (int i = 0; i < 9; i++)
                    regs[i] = '0;
                regs[R_H] = {16'd0, h_cfg};
                regs[R_CPP] = {18'd0, cpp_cfg};
                regs[R_SP] = {18'd0, sp_cfg};
                mbr = '0;
                mpc = entry_cfg;
                rd_pend = 0;
                fetch_pend = 0;
            end
            OP_STEP: microcycle();
            default: ;
        endcase
        r.tos = regs[R_TOS];
        r.mpc = mpc;
        r.pc = regs[R_PC];
        r.sp = regs[R_SP];
        r.halt = (cs_mem[mpc][3:0] == B_HALT);
        return r;
    endfunction

    function automatic logic [35:0] random_microword();
        logic [35:0] w;
        logic [5:0] codes [16];
        codes = '{ALU_A, ALU_B, ALU_NA, ALU_NB, ALU_ADD, ALU_ADD1, ALU_INCA, ALU_INCB,
                  ALU_SUB, ALU_DECB, ALU_NEGA, ALU_AND, ALU_OR, ALU_ZERO, ALU_ONE, ALU_MONE};
        w = 36'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 8)
            w[21:16] = codes[$urandom_range(0, 15)];
        if ($urandom_range(0, 9) < 7 && w[3:0] > B_OPC)
            w[3:0] = 4'($urandom_range(0, 8));
        return w;
    endfunction

    function automatic int gap_len();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // leaves start high after the accepting edge
    task automatic send_item(logic [2:0] o, logic [13:0] a, logic [35:0] d,
                             bit known, logic [31:0] rd_known);
        int g;
        outcome_t r;
        g = gap_len();
        if (g > 0)
        begin
            @(negedge clk) start <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        op <= o;
        address <= a;
        data <= d;
        do @(posedge clk); while (busy);
        r = predict_item(o, a, d);
        if (known)
            r.rd = rd_known;
        pending_results.push_back(r);
        items++;
        if (o == OP_STEP)
            steps++;
    endtask

    task automatic settle();
        @(negedge clk) start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ENTRY: entry_cfg = val[8:0];
            CFG_H:     h_cfg = val;
            CFG_CPP:   cpp_cfg = val[13:0];
            default:   sp_cfg = val[13:0];
        endcase
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        outcome_t got, want;
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("microprogrammed_stack_cpu_datapath_top regression: fail");
            $finish;
        end
        if (rst_n && done)
        begin
            got = '{read_data, top_of_stack, micro_pc, program_counter, stack_pointer, halted};
            results++;
            if (got.halt)
                halts++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d", cycles);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch %0d: exp rd=%h tos=%h mpc=%h pc=%h sp=%h halt=%b",
                                 results, want.rd, want.tos, want.mpc, want.pc, want.sp,
                                 want.halt, "\n            got rd=%h tos=%h mpc=%h pc=%h sp=%h halt=%b",
                                 got.rd, got.tos, got.mpc, got.pc, got.sp, got.halt);
                end
            end
        end
    end

    initial
    begin
        row_t rows [$];
        logic [2:0] o;
        logic [13:0] a;
        logic [35:0] d;
        int p;
        logic [15:0] setting [4];

        for (int i = 0; i < MEMORY_WORDS; i++)
            dmem[i] = '0;
        for (int i = 0; i < 9; i++)
            regs[i] = '0;
        mbr = '0;
        mpc = '0;
        rd_pend = 0;
        fetch_pend = 0;
        entry_cfg = '0;
        h_cfg = '0;
        cpp_cfg = '0;
        sp_cfg = '0;

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // fill the control store, word 0 first, so mpc never points at an unwritten word
        no_gaps = 1;
        for (int i = 0; i < CONTROL_WORDS; i++)
            send_item(OP_LOAD_CW, 14'(i), random_microword(), 0, '0);
        no_gaps = 0;

        rows = '{
            '{OP_WRITE_MEM, 14'd0, 36'hF_FFFF_FFFF, 0, '0},
            '{OP_WRITE_MEM, 14'd16383, 36'h0_8000_0000, 0, '0},
            '{OP_READ_MEM, 14'd0, 36'd0, 1, 32'hFFFF_FFFF},
            '{OP_READ_MEM, 14'd16383, 36'd0, 1, 32'h8000_0000},
            '{OP_READ_MEM, 14'd5, 36'hF_FFFF_FFFF, 1, 32'd0},
            '{OP_WRITE_MEM, 14'd1, 36'h0_1234_5678, 0, '0},
            '{OP_LOAD_CW, 14'd600, 36'h0_0000_000F, 0, '0},
            '{OP_LOAD_CW, 14'd16383, 36'hF_FFFF_FFFF, 0, '0},
            '{OP_LOAD_CW, 14'd0, {9'd511, 3'b111, 2'b11, ALU_ONE, 9'h1FF, 3'b111, B_HALT}, 0, '0},
            '{OP_LOAD_CW, 14'd511, {9'd0, 3'b001, 2'b00, ALU_ZERO, 9'h100, 3'b000, B_MDR}, 0, '0},
            '{OP_STEP + 3'd1, 14'd3, 36'd0, 0, '0},
            '{OP_STEP + 3'd2, 14'd3, 36'd0, 0, '0},
            '{OP_STEP + 3'd3, 14'd3, 36'd0, 1, 32'd0},
            '{OP_RESTART, 14'd0, 36'd0, 1, 32'd0},
            '{OP_STEP, 14'd0, 36'd0, 0, '0},
            '{OP_STEP, 14'd0, 36'd0, 0, '0},
            '{OP_STEP, 14'd0, 36'd0, 0, '0},
            '{OP_STEP, 14'd0, 36'd0, 0, '0},
            '{OP_STEP, 14'h3FFF, 36'hF_FFFF_FFFF, 0, '0},
            '{OP_READ_MEM, 14'd1, 36'd0, 1, 32'h1234_5678}
        };
        foreach (rows[i])
            send_item(rows[i].op, rows[i].addr, rows[i].data, rows[i].known, rows[i].rd);

        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            if (ph == 0)
                setting = '{16'h01FF, 16'hFFFF, 16'h3FFF, 16'h3FFF};
            else if (ph == 1)
                setting = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
            else
                setting = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
            write_reg(CFG_ENTRY, setting[0]);
            write_reg(CFG_H, setting[1]);
            write_reg(CFG_CPP, setting[2]);
            write_reg(CFG_SP, setting[3]);
            send_item(OP_RESTART, '0, '0, 0, '0);
            for (int k = 0; k < 140; k++)
            begin
                if (k % 35 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                p = $urandom_range(0, 99);
                a = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 63));
                d = 36'({$urandom, $urandom});
                if (p < 60)
                    o = OP_STEP;
                else if (p < 70)
                begin
                    o = OP_LOAD_CW;
                    if ($urandom_range(0, 4) != 0)
                        a = 14'($urandom_range(0, CONTROL_WORDS - 1));
                    d = random_microword();
                end
                else if (p < 80)
                    o = OP_WRITE_MEM;
                else if (p < 88)
                    o = OP_READ_MEM;
                else if (p < 94)
                    o = OP_RESTART;
                else
                    o = 3'($urandom_range(5, 7));
                send_item(o, a, d, 0, '0);
            end
        end
        no_gaps = 0;
        settle();

        $display("%0d items sent, %0d microcycles, %0d results, %0d reporting halt",
                 items, steps, results, halts);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("microprogrammed_stack_cpu_datapath_top regression: pass");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("microprogrammed_stack_cpu_datapath_top regression: fail");
        end
        $finish;
    end

endmodule
